// ===== design/ll1_table_parser_macros.svh =====
// Assertion macros for the LL(1) parser checker
`ifndef LL1_TABLE_PARSER_MACROS_SVH
`define LL1_TABLE_PARSER_MACROS_SVH
// Implication checked at every clock, held off during reset
`define LL1_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ll1 check failed");
// Next-cycle implication
`define LL1_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ll1 check failed");
`endif

// ===== design/ll1p_pkg.sv =====
// Package: grammar tables, symbol codes and sequencer states of the LL(1) parser
`default_nettype none
package ll1p_pkg;
  localparam int StackDepth = 64;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);
  localparam int GuardLimit = 8 * StackDepth + 64;
  localparam int GuardW = $clog2(GuardLimit + 2);
  localparam int NumNonterm = 23;
  localparam int TermBase = 23;
  localparam int MaxRhs = 8;

  typedef logic [5:0] sym_t;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0, ST_ACCEPTED = 3'd1, ST_NO_PROD = 3'd2, ST_MISMATCH = 3'd3,
    ST_TRAILING = 3'd4, ST_INCOMPLETE = 3'd5, ST_OVERFLOW = 3'd6, ST_AFTER_FAIL = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DECIDE, S_PUSH, S_FINISH, S_REARM, S_OUT, S_INIT
  } seq_state_e;

  localparam logic [5:0] CodeEmpty = 6'd0;
  localparam logic [5:0] CodeLam = 6'd1;

  // production table: 0 empty, 1 lambda, k>=2 production k-2
  function automatic logic [5:0] ptable(input logic [4:0] nt, input logic [4:0] t);
    logic [5:0] c;
    c = CodeEmpty;
    case (nt)
      5'd0: if (t == 5'd0) c = 6'd2;
      5'd1: if (t == 5'd7) c = CodeLam; else if (t >= 5'd17 && t <= 5'd21) c = 6'd3;
      5'd2: begin
        if (t == 5'd4 || t == 5'd6 || t == 5'd7 || t == 5'd10 || (t >= 5'd12 && t <= 5'd16))
          c = CodeLam;
        else if (t >= 5'd17 && t <= 5'd21) c = 6'd3;
        else if (t >= 5'd22) c = 6'd4;
      end
      5'd3: if (t >= 5'd17 && t <= 5'd21) c = 6'd5;
      5'd4: if (t == 5'd7) c = 6'd6; else if (t >= 5'd17 && t <= 5'd21) c = 6'd7;
      5'd5: if (t == 5'd6) c = CodeLam; else if (t == 5'd7) c = 6'd8;
      5'd6: if (t == 5'd5) c = 6'd9;
      5'd7: begin
        if (t == 5'd2) c = CodeLam;
        else if (t == 5'd8 || (t >= 5'd17 && t <= 5'd21)) c = 6'd10;
      end
      5'd8: begin
        if (t == 5'd2) c = CodeLam;
        else if (t == 5'd8 || t == 5'd13 || t == 5'd14) c = 6'd11;
      end
      5'd9: if (t == 5'd8) c = 6'd12; else if (t >= 5'd17 && t <= 5'd21) c = 6'd13;
      5'd10: if (t == 5'd8) c = 6'd14;
      5'd11: begin
        if (t == 5'd7 || t == 5'd11) c = 6'd15;
        else if (t >= 5'd17 && t <= 5'd21) c = CodeLam;
      end
      5'd12: if (t >= 5'd17 && t <= 5'd21) c = 6'd16;
      5'd13: if (t == 5'd9 || t == 5'd13 || t == 5'd14 || t >= 5'd17) c = 6'd17;
      5'd14: begin
        if (t == 5'd4 || t == 5'd10) c = CodeLam;
        else if (t == 5'd13) c = 6'd18;
        else if (t == 5'd14) c = 6'd19;
      end
      5'd15: if (t == 5'd9 || t == 5'd13 || t == 5'd14 || t >= 5'd17) c = 6'd20;
      5'd16: begin
        if (t == 5'd4 || t == 5'd10 || t == 5'd13 || t == 5'd14) c = CodeLam;
        else if (t == 5'd15) c = 6'd21;
        else if (t == 5'd16) c = 6'd22;
      end
      5'd17: begin
        if (t == 5'd9) c = 6'd23;
        else if (t == 5'd13 || t == 5'd14 || t >= 5'd22) c = 6'd24;
        else if (t >= 5'd17) c = 6'd25;
      end
      5'd18: if (t == 5'd13 || t == 5'd14 || t >= 5'd22) c = 6'd26;
      5'd19: begin
        if (t == 5'd4 || t == 5'd15 || t == 5'd16) c = CodeLam;
        else if (t >= 5'd22) c = 6'd27;
      end
      5'd20: begin
        if (t == 5'd13) c = 6'd28;
        else if (t == 5'd14) c = 6'd29;
        else if (t >= 5'd22) c = CodeLam;
      end
      5'd21: if (t >= 5'd17 && t <= 5'd21) c = 6'(t) + 6'd13;
      5'd22: if (t >= 5'd22) c = 6'(t) + 6'd13;
      default: c = CodeEmpty;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] rhs_len(input logic [5:0] p);
    logic [3:0] n;
    case (p)
      6'd0: n = 4'd8;
      6'd1, 6'd2, 6'd5, 6'd8, 6'd9, 6'd15, 6'd18, 6'd25: n = 4'd2;
      6'd3, 6'd14: n = 4'd4;
      6'd4, 6'd6, 6'd16, 6'd17, 6'd19, 6'd20, 6'd21, 6'd24: n = 4'd3;
      6'd12: n = 4'd7;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic sym_t rhs_sym(input logic [5:0] p, input logic [2:0] k);
    sym_t s;
    s = 6'd0;
    case (p)
      6'd0: case (k)
        3'd0: s = 6'd23; 3'd1: s = 6'd1; 3'd2: s = 6'd27; 3'd3: s = 6'd26;
        3'd4: s = 6'd3; 3'd5: s = 6'd24; 3'd6: s = 6'd7; default: s = 6'd25;
      endcase
      6'd1: s = (k == 3'd0) ? 6'd21 : 6'd2;
      6'd2: s = (k == 3'd0) ? 6'd22 : 6'd2;
      6'd3: case (k)
        3'd0: s = 6'd4; 3'd1: s = 6'd29; 3'd2: s = 6'd6; default: s = 6'd27;
      endcase
      6'd4: case (k) 3'd0: s = 6'd1; 3'd1: s = 6'd30; default: s = 6'd4; endcase
      6'd5: s = (k == 3'd0) ? 6'd1 : 6'd5;
      6'd6: case (k) 3'd0: s = 6'd30; 3'd1: s = 6'd4; default: s = 6'd5; endcase
      6'd7: s = 6'd28;
      6'd8: s = (k == 3'd0) ? 6'd9 : 6'd7;
      6'd9: s = (k == 3'd0) ? 6'd7 : 6'd8;
      6'd10: s = 6'd10;
      6'd11: s = 6'd12;
      6'd12: case (k)
        3'd0: s = 6'd31; 3'd1: s = 6'd32; 3'd2: s = 6'd11; 3'd3: s = 6'd30;
        3'd4: s = 6'd1; 3'd5: s = 6'd33; default: s = 6'd27;
      endcase
      6'd13: s = 6'd34;
      6'd14: case (k)
        3'd0: s = 6'd1; 3'd1: s = 6'd35; 3'd2: s = 6'd13; default: s = 6'd27;
      endcase
      6'd15: s = (k == 3'd0) ? 6'd15 : 6'd14;
      6'd16: case (k) 3'd0: s = 6'd36; 3'd1: s = 6'd15; default: s = 6'd14; endcase
      6'd17: case (k) 3'd0: s = 6'd37; 3'd1: s = 6'd15; default: s = 6'd14; endcase
      6'd18: s = (k == 3'd0) ? 6'd17 : 6'd16;
      6'd19: case (k) 3'd0: s = 6'd38; 3'd1: s = 6'd17; default: s = 6'd16; endcase
      6'd20: case (k) 3'd0: s = 6'd39; 3'd1: s = 6'd17; default: s = 6'd16; endcase
      6'd21: case (k) 3'd0: s = 6'd32; 3'd1: s = 6'd13; default: s = 6'd33; endcase
      6'd22: s = 6'd18;
      6'd23: s = 6'd1;
      6'd24: case (k) 3'd0: s = 6'd20; 3'd1: s = 6'd22; default: s = 6'd19; endcase
      6'd25: s = (k == 3'd0) ? 6'd22 : 6'd19;
      6'd26: s = 6'd36;
      6'd27: s = 6'd37;
      default: s = p + 6'd12; // single terminal productions 28..42 -> 40..54
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== design/ll1p_stack.sv =====
// Symbol stack memory: one write port, one registered read port
`default_nettype none
module ll1p_stack (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ll1p_pkg::AddrW-1:0] waddr_i,
  input  wire ll1p_pkg::sym_t        wdata_i,
  input  wire logic [ll1p_pkg::AddrW-1:0] raddr_i,
  output      ll1p_pkg::sym_t        rdata_o
);
  import ll1p_pkg::*;
  sym_t mem_q [StackDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/ll1_table_parser.sv =====
// LL(1) parser: top of stack fetched from memory, one table step per fetch and decide.
// Steps: a table step (pop, expand or match) is a fetch and a decide, an expand then
//   pushes its symbols one per push state; finish, on a last token rearm, then output.
//   After a failure a token goes straight to finish. One token at a time: the next is
//   taken back in idle, after the result is registered and the output is not stalled.
// Reset: the init state writes the start symbol; a rearm after the last token rewrites it.
`default_nettype none
module ll1_table_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [4:0] token_id_i,
  input  wire logic       last_token_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [2:0] status_o,
  output      logic [5:0] fail_symbol_o,
  output      logic       program_done_o
);
  import ll1p_pkg::*;

  seq_state_e state_q, state_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic failed_q, failed_d;
  logic [4:0] tok_q, tok_d;
  logic last_q, last_d;
  logic [GuardW-1:0] guard_q, guard_d;
  logic [5:0] prod_q, prod_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] st_q, st_d;
  logic [5:0] fs_q, fs_d;
  logic [2:0] ost_q, ost_d;
  logic [5:0] ofs_q, ofs_d;
  logic odone_q, odone_d;
  logic ovalid_q, ovalid_d;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  sym_t wdata, top;
  logic [5:0] code;

  ll1p_stack u_stack (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(top)
  );

  assign code = (top < 6'(NumNonterm)) ? ptable(top[4:0], tok_q) : CodeEmpty;
  // read the top of the stack as it stands after this cycle's pop or push
  assign raddr = AddrW'(sp_d - SpW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = failed_q ? S_FINISH : S_FETCH;
      S_FETCH: state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_FINISH;
        if (sp_q != '0 && guard_q <= GuardW'(GuardLimit) && top < 6'(TermBase)) begin
          if (code == CodeLam) state_d = S_FETCH;
          else if (code != CodeEmpty &&
                   ({1'b0, sp_q} - (SpW+1)'(1) + (SpW+1)'(rhs_len(code - 6'd2)))
                     <= (SpW+1)'(StackDepth)) state_d = S_PUSH;
        end
      end
      S_PUSH: if (cnt_q == 4'd1) state_d = S_FETCH;
      S_FINISH: state_d = last_q ? S_REARM : S_OUT;
      S_REARM: state_d = S_OUT;
      S_OUT: if (!ovalid_q || !out_stall_i) state_d = S_IDLE;
      S_INIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    sp_d = sp_q; failed_d = failed_q; tok_d = tok_q; last_d = last_q;
    guard_d = guard_q; prod_d = prod_q; cnt_d = cnt_q; st_d = st_q; fs_d = fs_q;
    ost_d = ost_q; ofs_d = ofs_q; odone_d = odone_q;
    ovalid_d = ovalid_q && out_stall_i;
    we = 1'b0; waddr = AddrW'(sp_q); wdata = rhs_sym(prod_q, 3'(cnt_q - 4'd1));
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        tok_d = token_id_i; last_d = last_token_i; guard_d = '0;
        st_d = failed_q ? ST_AFTER_FAIL : ST_CONSUMED; fs_d = '0;
      end
      S_DECIDE: begin
        guard_d = guard_q + GuardW'(1);
        if (sp_q == '0) begin
          st_d = ST_TRAILING;
        end else if (guard_q > GuardW'(GuardLimit)) begin
          st_d = ST_OVERFLOW; fs_d = top;
        end else if (top >= 6'(TermBase)) begin
          if (top == 6'(tok_q) + 6'(TermBase)) sp_d = sp_q - SpW'(1);
          else begin st_d = ST_MISMATCH; fs_d = top; end
        end else if (code == CodeEmpty) begin
          st_d = ST_NO_PROD; fs_d = top;
        end else if (code == CodeLam) begin
          sp_d = sp_q - SpW'(1);
        end else if (state_d == S_PUSH) begin
          sp_d = sp_q - SpW'(1); prod_d = code - 6'd2; cnt_d = rhs_len(code - 6'd2);
        end else begin
          st_d = ST_OVERFLOW; fs_d = top;
        end
      end
      S_PUSH: begin
        // push right-hand side reversed: last symbol first
        we = 1'b1; sp_d = sp_q + SpW'(1); cnt_d = cnt_q - 4'd1;
      end
      S_FINISH: begin
        // top holds the stack top left after the consuming pop
        if (st_q == ST_CONSUMED && last_q) begin
          if (sp_q == '0) st_d = ST_ACCEPTED;
          else begin st_d = ST_INCOMPLETE; fs_d = top; end
        end
        if (!failed_q && st_q >= ST_NO_PROD) failed_d = 1'b1;
      end
      S_INIT, S_REARM: begin
        we = 1'b1; waddr = '0; wdata = '0; sp_d = SpW'(1); failed_d = 1'b0;
      end
      S_OUT: if (!ovalid_q || !out_stall_i) begin
        ovalid_d = 1'b1; ost_d = st_q; ofs_d = fs_q; odone_d = last_q;
      end
      default: ;
    endcase
  end

  // start in init so the start symbol is written before the first item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; sp_q <= SpW'(1); failed_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; sp_q <= sp_d; failed_q <= failed_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d; last_q <= last_d; guard_q <= guard_d; prod_q <= prod_d;
    cnt_q <= cnt_d; st_q <= st_d; fs_q <= fs_d;
    ost_q <= ost_d; ofs_q <= ofs_d; odone_q <= odone_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign status_o = ost_q;
  assign fail_symbol_o = ofs_q;
  assign program_done_o = odone_q;
endmodule
`default_nettype wire

// ===== design/ll1p_checker.sv =====
// Port checker for the LL(1) parser, bound to the top level
`default_nettype none
`include "ll1_table_parser_macros.svh"
module ll1p_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic [5:0] fail_symbol_o,
  input wire logic       program_done_o
);
  import ll1p_pkg::*;
  `LL1_ASSERT_IMP(a_clean_fs, clk_i, rst_ni, out_valid_o && (status_o == ST_CONSUMED || status_o == ST_ACCEPTED || status_o == ST_TRAILING || status_o == ST_AFTER_FAIL), fail_symbol_o == 6'd0)
  `LL1_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `LL1_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(program_done_o))
endmodule
bind ll1_table_parser ll1p_checker u_ll1p_checker (.*);
`default_nettype wire
